[src/mwm_pkg.sv]
// shared widths, reset values and register indexes for the mecanum wheel mixer
package mwm_pkg;

  localparam int unsigned AXIS_W   = 8;
  localparam int unsigned DRIVE_W  = 13;
  localparam int unsigned DZ_W     = 7;
  localparam int unsigned LIM_W    = 8;
  localparam int unsigned GAIN_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // wheel mix spans -383..384, magnitude fits 9 bits
  localparam int unsigned WHEEL_W = 10;
  localparam int unsigned MAG_W   = 9;
  localparam int unsigned PROD_W  = MAG_W + LIM_W;
  localparam int unsigned QUO_W   = 8;

  localparam logic [DZ_W-1:0]   DEADZONE_RESET   = 7'd10;
  localparam logic [LIM_W-1:0]  NORM_LIMIT_RESET = 8'd100;
  localparam logic [GAIN_W-1:0] DRIVE_GAIN_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE   = 2'd0,
    CFG_NORM_LIMIT = 2'd1,
    CFG_DRIVE_GAIN = 2'd2
  } cfg_idx_t;

  // one item in flight through the divider stages
  typedef struct packed {
    logic [3:0][WHEEL_W-1:0] w;
    logic [3:0][MAG_W-1:0]   rem;
    logic [3:0][QUO_W-1:0]   quo;
    logic [3:0][QUO_W-1:0]   low;
    logic [MAG_W-1:0]        m;
    logic                    scaled;
  } div_t;

endpackage

[src/mecanum_wheel_mixer.sv]
// mecanum wheel mixer: deadzone, mix, normalize by pipelined division, gain
//
// Input beat: stick_x, stick_y, turn_axis on in_valid/in_ready. Result beat:
// front_left, front_right, rear_left, rear_right, was_scaled on
// out_valid/out_ready. Registers deadzone, norm_limit and drive_gain are
// written over cfg_valid/cfg_index/cfg_data; cfg_ready is always high and
// writes are expected only while the pipeline is empty.
// An accepted input beat passes through these registered stages in order: mix,
// max and multiply, divider setup, four divider stages of two quotient bits
// each, and the gain multiply into the output register.
// Without stalls, one beat per cycle passes; the divider is fully pipelined.
// Each stage holds its own valid bit and advances whenever the stage after it
// is empty or moving, so a stalled receiver only backs up the pipeline
// stage by stage; in_ready drops once every stage is full. Nothing is lost
// or repeated under stalls.
// Reset empties the pipeline and loads deadzone 10, norm_limit 100 and
// drive_gain 8.
module mecanum_wheel_mixer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   stick_x,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   stick_y,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   turn_axis,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mwm_pkg::DRIVE_W-1:0]  front_left,
  output logic signed [mwm_pkg::DRIVE_W-1:0]  front_right,
  output logic signed [mwm_pkg::DRIVE_W-1:0]  rear_left,
  output logic signed [mwm_pkg::DRIVE_W-1:0]  rear_right,
  output logic                                was_scaled,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mwm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mwm_pkg::*;

  localparam int unsigned DIV_STAGES = QUO_W / 2;

  // configuration registers
  logic [DZ_W-1:0]   deadzone;
  logic [LIM_W-1:0]  norm_limit;
  logic [GAIN_W-1:0] drive_gain;

  // stage a: mixed wheels
  logic                     a_v;
  logic [3:0][WHEEL_W-1:0]  a_w;
  logic [3:0][WHEEL_W-1:0]  a_w_next;

  // stage b: magnitudes, max, products
  logic                     b_v;
  logic [3:0][WHEEL_W-1:0]  b_w;
  logic [3:0][PROD_W-1:0]   b_prod;
  logic [MAG_W-1:0]         b_m;
  logic [3:0][PROD_W-1:0]   b_prod_next;
  logic [MAG_W-1:0]         b_m_next;

  // divider stages
  logic [DIV_STAGES:0]      dv;
  div_t                     dd [DIV_STAGES+1];
  div_t                     dd_next [DIV_STAGES+1];

  // output stage next values
  logic [3:0][DRIVE_W-1:0]  drive_next;

  // per-stage ready chain
  logic                     o_rdy;
  logic [DIV_STAGES:0]      d_rdy;
  logic                     b_rdy;
  logic                     a_rdy;

  // one restoring division step: returns quotient bit and new remainder
  function automatic logic [MAG_W:0] div_step(logic [MAG_W-1:0] rem, logic din,
                                              logic [MAG_W-1:0] m);
    logic [MAG_W:0] t;
    logic [MAG_W:0] d;
    begin
      t = {rem, din};
      d = t - {1'b0, m};
      if (t >= {1'b0, m}) begin
        return {1'b1, d[MAG_W-1:0]};
      end
      return {1'b0, t[MAG_W-1:0]};
    end
  endfunction

  // zero an axis whose magnitude is below the deadzone
  function automatic logic signed [AXIS_W:0] dead(logic signed [AXIS_W-1:0] v,
                                                  logic [DZ_W-1:0] dz);
    logic signed [AXIS_W:0] vx;
    logic signed [AXIS_W:0] dzx;
    begin
      vx  = {v[AXIS_W-1], v};
      dzx = $signed({2'b00, dz});
      if (vx > -dzx && vx < dzx) begin
        return '0;
      end
      return vx;
    end
  endfunction

  // ready chain from the output back to the input
  always_comb begin
    o_rdy = ~out_valid | out_ready;
    d_rdy[DIV_STAGES] = ~dv[DIV_STAGES] | o_rdy;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      d_rdy[k] = ~dv[k] | d_rdy[k+1];
    end
    b_rdy = ~b_v | d_rdy[0];
    a_rdy = ~a_v | b_rdy;
  end

  assign in_ready  = a_rdy;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone   <= DEADZONE_RESET;
      norm_limit <= NORM_LIMIT_RESET;
      drive_gain <= DRIVE_GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEADZONE:   deadzone   <= cfg_data[DZ_W-1:0];
        CFG_NORM_LIMIT: norm_limit <= cfg_data[LIM_W-1:0];
        CFG_DRIVE_GAIN: drive_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage a logic: deadzone, negate forward axis, mix
  always_comb begin
    logic signed [AXIS_W:0]  sx;
    logic signed [AXIS_W:0]  fy;
    logic signed [AXIS_W:0]  tw;
    logic signed [WHEEL_W-1:0] s10;
    logic signed [WHEEL_W-1:0] f10;
    logic signed [WHEEL_W-1:0] t10;
    sx  = dead(stick_x, deadzone);
    fy  = dead(stick_y, deadzone);
    tw  = dead(turn_axis, deadzone);
    s10 = WHEEL_W'(sx);
    f10 = -WHEEL_W'(fy);
    t10 = WHEEL_W'(tw);
    a_w_next[0] = f10 - s10 - t10;
    a_w_next[1] = f10 + s10 + t10;
    a_w_next[2] = f10 + s10 - t10;
    a_w_next[3] = f10 - s10 + t10;
  end

  // stage b logic: magnitudes, largest magnitude, magnitude times limit
  always_comb begin
    logic [3:0][MAG_W-1:0] mg;
    logic [WHEEL_W-1:0]    neg;
    logic [MAG_W-1:0]      m01;
    logic [MAG_W-1:0]      m23;
    for (int i = 0; i < 4; i++) begin
      neg   = -a_w[i];
      mg[i] = a_w[i][WHEEL_W-1] ? neg[MAG_W-1:0] : a_w[i][MAG_W-1:0];
      b_prod_next[i] = PROD_W'(mg[i]) * PROD_W'(norm_limit);
    end
    m01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
    m23 = (mg[2] > mg[3]) ? mg[2] : mg[3];
    b_m_next = (m01 > m23) ? m01 : m23;
  end

  // divider setup and two quotient bits per stage
  always_comb begin
    logic [MAG_W:0] st;
    dd_next[0].w      = b_w;
    dd_next[0].m      = b_m;
    dd_next[0].scaled = b_m > MAG_W'(norm_limit);
    for (int i = 0; i < 4; i++) begin
      dd_next[0].rem[i] = b_prod[i][PROD_W-1:QUO_W];
      dd_next[0].low[i] = b_prod[i][QUO_W-1:0];
      dd_next[0].quo[i] = '0;
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      dd_next[k+1] = dd[k];
      for (int i = 0; i < 4; i++) begin
        st = div_step(dd[k].rem[i], dd[k].low[i][QUO_W-1-2*k], dd[k].m);
        dd_next[k+1].quo[i][QUO_W-1-2*k] = st[MAG_W];
        st = div_step(st[MAG_W-1:0], dd[k].low[i][QUO_W-2-2*k], dd[k].m);
        dd_next[k+1].quo[i][QUO_W-2-2*k] = st[MAG_W];
        dd_next[k+1].rem[i] = st[MAG_W-1:0];
      end
    end
  end

  // output stage logic: restore sign, pick scaled value, apply gain
  always_comb begin
    logic signed [WHEEL_W-1:0]   val;
    logic signed [WHEEL_W-1:0]   qv;
    logic signed [DRIVE_W+1:0]   prod;
    for (int i = 0; i < 4; i++) begin
      qv = $signed({2'b00, dd[DIV_STAGES].quo[i]});
      if (dd[DIV_STAGES].scaled) begin
        val = dd[DIV_STAGES].w[i][WHEEL_W-1] ? -qv : qv;
      end else begin
        val = $signed(dd[DIV_STAGES].w[i]);
      end
      prod = (DRIVE_W+2)'(val) * $signed({{(DRIVE_W+2-GAIN_W){1'b0}}, drive_gain});
      drive_next[i] = prod[DRIVE_W-1:0];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      dv        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v <= in_valid;
      end
      if (b_rdy) begin
        b_v <= a_v;
      end
      if (d_rdy[0]) begin
        dv[0] <= b_v;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (d_rdy[k]) begin
          dv[k] <= dv[k-1];
        end
      end
      if (o_rdy) begin
        out_valid <= dv[DIV_STAGES];
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_w <= a_w_next;
    end
    if (b_rdy && a_v) begin
      b_w    <= a_w;
      b_prod <= b_prod_next;
      b_m    <= b_m_next;
    end
    if (d_rdy[0] && b_v) begin
      dd[0] <= dd_next[0];
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (d_rdy[k] && dv[k-1]) begin
        dd[k] <= dd_next[k];
      end
    end
    if (o_rdy && dv[DIV_STAGES]) begin
      front_left  <= drive_next[0];
      front_right <= drive_next[1];
      rear_left   <= drive_next[2];
      rear_right  <= drive_next[3];
      was_scaled  <= dd[DIV_STAGES].scaled;
    end
  end

endmodule
